FILE: design/roman_numeral_encoder_top_assert.svh
// ----------------------------------------------------------------------------
// Roman numeral encoder assertion macros
// Clocked property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef ROMAN_NUMERAL_ENCODER_TOP_ASSERT_SVH
`define ROMAN_NUMERAL_ENCODER_TOP_ASSERT_SVH

// checked outside reset
`define RNE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define RNE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: design/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg
// Widths, letter codes and digit-to-letter tables of the Roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

   localparam int unsigned VALUE_W  = 12;
   localparam int unsigned LETTER_W = 8;
   localparam int unsigned DIGIT_W  = 4;
   localparam int unsigned PLACES   = 4;
   localparam int unsigned PLACE_W  = 2;
   localparam int unsigned IDX_W    = 2;
   localparam int unsigned LEN_W    = 3;

   localparam logic [VALUE_W-1:0] VALUE_LIMIT = 12'd4000;

   // place codes, thousands first
   localparam logic [PLACE_W-1:0] PLACE_THOU = 2'd0;
   localparam logic [PLACE_W-1:0] PLACE_HUND = 2'd1;
   localparam logic [PLACE_W-1:0] PLACE_TENS = 2'd2;
   localparam logic [PLACE_W-1:0] PLACE_UNIT = 2'd3;

   // letter slot within a place
   localparam logic [1:0] SLOT_ONE  = 2'd0;
   localparam logic [1:0] SLOT_FIVE = 2'd1;
   localparam logic [1:0] SLOT_TEN  = 2'd2;

   localparam logic [LETTER_W-1:0] ASCII_NUL = 8'h00;
   localparam logic [LETTER_W-1:0] ASCII_I   = 8'h49;
   localparam logic [LETTER_W-1:0] ASCII_V   = 8'h56;
   localparam logic [LETTER_W-1:0] ASCII_X   = 8'h58;
   localparam logic [LETTER_W-1:0] ASCII_L   = 8'h4C;
   localparam logic [LETTER_W-1:0] ASCII_C   = 8'h43;
   localparam logic [LETTER_W-1:0] ASCII_D   = 8'h44;
   localparam logic [LETTER_W-1:0] ASCII_M   = 8'h4D;

   typedef logic [DIGIT_W-1:0] digit_type;

   // dig[0] is the thousands digit
   typedef struct packed {
      logic                    err;
      digit_type [PLACES-1:0]  dig;
   } item_type;

   function automatic logic [LEN_W-1:0] digit_len(input digit_type d);
      logic [LEN_W-1:0] len;
      case (d)
         4'd1, 4'd5:        len = 3'd1;
         4'd2, 4'd4, 4'd6,
         4'd9:              len = 3'd2;
         4'd3, 4'd7:        len = 3'd3;
         4'd8:              len = 3'd4;
         default:           len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [1:0] digit_slot(input digit_type d,
                                             input logic [IDX_W-1:0] i);
      logic [1:0] slot;
      slot = SLOT_ONE;
      case (d)
         4'd4:                   slot = (i == 2'd1) ? SLOT_FIVE : SLOT_ONE;
         4'd5, 4'd6, 4'd7, 4'd8: slot = (i == 2'd0) ? SLOT_FIVE : SLOT_ONE;
         4'd9:                   slot = (i == 2'd1) ? SLOT_TEN : SLOT_ONE;
         default:                slot = SLOT_ONE;
      endcase
      return slot;
   endfunction

   function automatic logic [LETTER_W-1:0] place_letter(input logic [PLACE_W-1:0] p,
                                                        input logic [1:0] slot);
      logic [LETTER_W-1:0] one, five, ten;
      unique case (p)
         PLACE_THOU: begin one = ASCII_M; five = ASCII_M; ten = ASCII_M; end
         PLACE_HUND: begin one = ASCII_C; five = ASCII_D; ten = ASCII_M; end
         PLACE_TENS: begin one = ASCII_X; five = ASCII_L; ten = ASCII_C; end
         PLACE_UNIT: begin one = ASCII_I; five = ASCII_V; ten = ASCII_X; end
         default:    begin one = ASCII_NUL; five = ASCII_NUL; ten = ASCII_NUL; end
      endcase
      unique case (slot)
         SLOT_ONE:  return one;
         SLOT_FIVE: return five;
         SLOT_TEN:  return ten;
         default:   return one;
      endcase
   endfunction

endpackage

FILE: design/rne_split.sv
// ----------------------------------------------------------------------------
// rne_split
// Input register and decimal digit split with range check.
// ----------------------------------------------------------------------------
module rne_split
   import rne_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               take,
   output logic               item_vld,
   output item_type           item
);

   logic               vld_ff, vld_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic               accept;

   assign busy   = reset | (vld_ff & ~take);
   assign accept = start & ~busy;
   assign vld_in = accept | (vld_ff & ~take);
   assign val_in = accept ? req_value : val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      val_ff <= val_in;
   end

   assign item_vld = vld_ff;

   always_comb begin
      logic [1:0] th;
      logic [9:0] r1;
      logic [3:0] hu;
      logic [6:0] r2;
      logic [3:0] te;
      logic [3:0] un;
      th = 2'd0;
      hu = 4'd0;
      te = 4'd0;
      // thousands by compare; remainder garbage only for rejected values
      if (val_ff >= 12'd3000) begin
         th = 2'd3;
         r1 = 10'(val_ff - 12'd3000);
      end else if (val_ff >= 12'd2000) begin
         th = 2'd2;
         r1 = 10'(val_ff - 12'd2000);
      end else if (val_ff >= 12'd1000) begin
         th = 2'd1;
         r1 = 10'(val_ff - 12'd1000);
      end else begin
         r1 = 10'(val_ff);
      end
      for (int k = 9; k >= 1; k--) begin
         if (hu == 4'd0 && r1 >= 10'(k * 100)) hu = 4'(k);
      end
      r2 = 7'(r1 - 10'(hu) * 10'd100);
      for (int k = 9; k >= 1; k--) begin
         if (te == 4'd0 && r2 >= 7'(k * 10)) te = 4'(k);
      end
      un = 4'(r2 - 7'(te) * 7'd10);
      item.err    = (val_ff == '0) || (val_ff >= VALUE_LIMIT);
      item.dig[0] = {2'b00, th};
      item.dig[1] = hu;
      item.dig[2] = te;
      item.dig[3] = un;
   end

endmodule

FILE: design/rne_emit.sv
// ----------------------------------------------------------------------------
// rne_emit
// Walks the digits of one item and issues one letter per cycle.
// ----------------------------------------------------------------------------
module rne_emit
   import rne_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                item_vld,
   input  item_type            item,
   output logic                take,
   output logic                rsp_valid,
   output logic [LETTER_W-1:0] rsp_letter,
   output logic                rsp_last,
   output logic                rsp_error
);

   logic                   act_ff, act_in;
   logic                   err_ff, err_in;
   digit_type [PLACES-1:0] dig_ff, dig_in;
   logic [PLACE_W-1:0]     place_ff, place_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;

   logic                rsp_valid_ff;
   logic [LETTER_W-1:0] rsp_letter_ff, rsp_letter_in;
   logic                rsp_last_ff;
   logic                rsp_error_ff;

   digit_type          cur_d;
   logic [LEN_W-1:0]   len;
   logic [PLACES-1:0]  later;
   logic [PLACE_W-1:0] nxt_place;
   logic [PLACE_W-1:0] first_place;
   logic               more;
   logic               cur_last;

   assign cur_d = dig_ff[place_ff];
   assign len   = digit_len(cur_d);
   assign more  = ({1'b0, idx_ff} + 3'd1) < len;

   always_comb begin
      nxt_place   = PLACE_THOU;
      first_place = PLACE_THOU;
      for (int q = 0; q < PLACES; q++) begin
         later[q] = (dig_ff[q] != '0) && (PLACE_W'(q) > place_ff);
      end
      // lowest index wins: scan from the units end
      for (int q = PLACES - 1; q >= 0; q--) begin
         if (later[q]) nxt_place = PLACE_W'(q);
         if (item.dig[q] != '0) first_place = PLACE_W'(q);
      end
   end

   assign cur_last = err_ff | (~more & (later == '0));
   assign take     = ~act_ff | cur_last;

   always_comb begin
      act_in   = act_ff;
      err_in   = err_ff;
      dig_in   = dig_ff;
      place_in = place_ff;
      idx_in   = idx_ff;
      if (take) begin
         act_in   = item_vld;
         err_in   = item.err;
         dig_in   = item.dig;
         place_in = first_place;
         idx_in   = '0;
      end else if (more) begin
         idx_in = idx_ff + 2'd1;
      end else begin
         place_in = nxt_place;
         idx_in   = '0;
      end
      rsp_letter_in = err_ff ? ASCII_NUL : place_letter(place_ff, digit_slot(cur_d, idx_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         act_ff       <= act_in;
         rsp_valid_ff <= act_ff;
      end
      err_ff        <= err_in;
      dig_ff        <= dig_in;
      place_ff      <= place_in;
      idx_ff        <= idx_in;
      rsp_letter_ff <= rsp_letter_in;
      rsp_last_ff   <= cur_last;
      rsp_error_ff  <= err_ff;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_letter = rsp_letter_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_error  = rsp_error_ff;

endmodule

FILE: design/roman_numeral_encoder_top.sv
// ----------------------------------------------------------------------------
// roman_numeral_encoder_top
// Converts a 12-bit number to its Roman numeral, one ASCII letter per result.
// ----------------------------------------------------------------------------
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+------------------
//  request  | req_value[11:0]                              | start & !busy
//  response | rsp_letter[7:0], rsp_last, rsp_error         | rsp_valid strobe
//
//  First letter of an item passes the input register, the walker registers
//  and the result register, then one letter per cycle; a numeral has 1 to 15
//  letters, and the letter walker issues one letter a cycle.
//  An item is taken each cycle while runs are one letter long; busy is high
//  while the input register is full and the walker is mid-run, and in reset.
//  Synchronous reset drops all items in flight. Results cannot be stalled.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_top
   import rne_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [VALUE_W-1:0]  req_value,
   output logic                rsp_valid,
   output logic [LETTER_W-1:0] rsp_letter,
   output logic                rsp_last,
   output logic                rsp_error
);

   logic     take;
   logic     item_vld;
   item_type item;

   rne_split u_split (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_value (req_value),
      .take      (take),
      .item_vld  (item_vld),
      .item      (item)
   );

   rne_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .item_vld   (item_vld),
      .item       (item),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp_letter (rsp_letter),
      .rsp_last   (rsp_last),
      .rsp_error  (rsp_error)
   );

endmodule

FILE: design/rne_checker.sv
// ----------------------------------------------------------------------------
// rne_checker
// Port-level checks of the Roman numeral encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "roman_numeral_encoder_top_assert.svh"

module rne_checker
   import rne_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                busy,
   input logic                rsp_valid,
   input logic [LETTER_W-1:0] rsp_letter,
   input logic                rsp_last,
   input logic                rsp_error
);

   `RNE_ASSERT(a_err_single, rsp_valid && rsp_error |-> rsp_last && rsp_letter == ASCII_NUL, "error item must be one NUL letter")
   `RNE_ASSERT(a_letter_code, rsp_valid && !rsp_error |-> rsp_letter == ASCII_I || rsp_letter == ASCII_V || rsp_letter == ASCII_X || rsp_letter == ASCII_L || rsp_letter == ASCII_C || rsp_letter == ASCII_D || rsp_letter == ASCII_M, "letter is not a numeral")
   `RNE_ASSERT(a_run_gapless, rsp_valid && !rsp_last |=> rsp_valid, "gap inside a letter run")
   `RNE_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result right after reset")
   `RNE_ASSERT_ALWAYS(a_busy_in_reset, reset |-> busy, "busy low during reset")

endmodule

bind roman_numeral_encoder_top rne_checker u_rne_checker (.*);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Roman numeral encoder. A table of directed
// numbers comes first, then random numbers sent in bursts with random gaps.
// Each accepted number is expanded into its expected letter run, and every
// rsp_valid strobe is checked in order against that run.
// ----------------------------------------------------------------------------
module tb_top
   import rne_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 470;
   localparam int DRAIN_CYCLES = 24;

   typedef struct {
      logic [LETTER_W-1:0] letter;
      logic                last;
      logic                err;
   } roman_letter_type;

   // typed rows carry their letters in text; typed with empty text means
   // an out-of-range number (single error result)
   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               typed;
      string              text;
   } numeral_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                busy;
   logic                rsp_valid;
   logic [LETTER_W-1:0] rsp_letter;
   logic                rsp_last;
   logic                rsp_error;

   // travels with req_value so the monitor knows how to expand the item
   logic                req_typed = 1'b0;
   string               req_text = "";

   roman_letter_type    expected_letters[$];
   int                  mismatch_count = 0;
   int                  cycle_count = 0;

   numeral_row_type     directed_rows[23] = '{
      '{12'd1,    1'b1, "I"},
      '{12'd0,    1'b1, ""},
      '{12'd3999, 1'b1, "MMMCMXCIX"},
      '{12'd4000, 1'b1, ""},
      '{12'd4095, 1'b1, ""},
      '{12'd3888, 1'b1, "MMMDCCCLXXXVIII"},
      '{12'd4,    1'b1, "IV"},
      '{12'd5,    1'b1, "V"},
      '{12'd9,    1'b1, "IX"},
      '{12'd40,   1'b1, "XL"},
      '{12'd90,   1'b1, "XC"},
      '{12'd400,  1'b1, "CD"},
      '{12'd900,  1'b1, "CM"},
      '{12'd1000, 1'b1, "M"},
      '{12'd3000, 1'b1, "MMM"},
      '{12'd1994, 1'b0, ""},
      '{12'd444,  1'b0, ""},
      '{12'd2048, 1'b0, ""},
      '{12'd2730, 1'b0, ""},
      '{12'd1365, 1'b0, ""},
      '{12'd3583, 1'b0, ""},
      '{12'd3500, 1'b0, ""},
      '{12'd777,  1'b0, ""}
   };

   roman_numeral_encoder_top u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_letter (rsp_letter),
      .rsp_last   (rsp_last),
      .rsp_error  (rsp_error)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void push_letter(input logic [LETTER_W-1:0] letter,
                                       input logic last, input logic err);
      roman_letter_type entry;
      entry.letter = letter;
      entry.last   = last;
      entry.err    = err;
      expected_letters.push_back(entry);
   endfunction

   // expands one number into its letter run, thousands first
   function automatic void predict_numeral(input logic [VALUE_W-1:0] value);
      logic [LETTER_W-1:0] one_of[4];
      logic [LETTER_W-1:0] five_of[4];
      logic [LETTER_W-1:0] ten_of[4];
      int unsigned         digit[4];
      int unsigned         v;
      v = value;
      if (v == 0 || v >= 4000) begin
         push_letter(ASCII_NUL, 1'b1, 1'b1);
         return;
      end
      one_of  = '{ASCII_M, ASCII_C, ASCII_X, ASCII_I};
      five_of = '{ASCII_M, ASCII_D, ASCII_L, ASCII_V};
      ten_of  = '{ASCII_M, ASCII_M, ASCII_C, ASCII_X};
      digit   = '{v / 1000, (v / 100) % 10, (v / 10) % 10, v % 10};
      for (int p = 0; p < 4; p++) begin
         case (digit[p])
            4: begin
               push_letter(one_of[p], 1'b0, 1'b0);
               push_letter(five_of[p], 1'b0, 1'b0);
            end
            9: begin
               push_letter(one_of[p], 1'b0, 1'b0);
               push_letter(ten_of[p], 1'b0, 1'b0);
            end
            default: begin
               if (digit[p] >= 5)
                  push_letter(five_of[p], 1'b0, 1'b0);
               for (int i = 0; i < digit[p] % 5; i++)
                  push_letter(one_of[p], 1'b0, 1'b0);
            end
         endcase
      end
      expected_letters[expected_letters.size()-1].last = 1'b1;
   endfunction

   function automatic void expect_typed(input string text);
      if (text.len() == 0) begin
         push_letter(ASCII_NUL, 1'b1, 1'b1);
         return;
      end
      for (int i = 0; i < text.len(); i++)
         push_letter(text[i], i == text.len() - 1, 1'b0);
   endfunction

   // results first, then the item accepted at this edge (its letters come later)
   always @(posedge clock) begin
      roman_letter_type want;
      if (!reset && rsp_valid) begin
         if (expected_letters.size() == 0) begin
            $display("%0t: unexpected result, expected none actual letter=%h last=%b error=%b",
                     $time, rsp_letter, rsp_last, rsp_error);
            mismatch_count++;
         end else begin
            want = expected_letters.pop_front();
            if (rsp_letter !== want.letter) begin
               $display("%0t: letter mismatch, expected %h actual %h",
                        $time, want.letter, rsp_letter);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last mismatch, expected %b actual %b",
                        $time, want.last, rsp_last);
               mismatch_count++;
            end
            if (rsp_error !== want.err) begin
               $display("%0t: error mismatch, expected %b actual %b",
                        $time, want.err, rsp_error);
               mismatch_count++;
            end
         end
      end
      if (!reset && start && !busy) begin
         if (req_typed)
            expect_typed(req_text);
         else
            predict_numeral(req_value);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d letters outstanding", $time,
                  expected_letters.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_numeral(input logic [VALUE_W-1:0] value, input logic typed,
                               input string text);
      start     <= 1'b1;
      req_value <= value;
      req_typed <= typed;
      req_text  <= text;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned kind;
      int unsigned long_run;
      kind = $urandom_range(0, 9);
      case (kind)
         0: return ($urandom_range(0, 3) == 0) ? 12'd0 : 12'($urandom_range(4000, 4095));
         1: return 12'($urandom_range(0, 4095));
         2: begin
            // digits of 3, 7 and 8 give the longest runs
            long_run = $urandom_range(0, 3) * 1000;
            for (int p = 100; p >= 1; p /= 10) begin
               case ($urandom_range(0, 2))
                  0: long_run += 3 * p;
                  1: long_run += 7 * p;
                  default: long_run += 8 * p;
               endcase
            end
            return 12'(long_run);
         end
         default: return 12'($urandom_range(1, 3999));
      endcase
   endfunction

   initial begin
      int burst_left;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_numeral(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].text);
         idle_gap($urandom_range(0, 3));
      end

      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (burst_left == 0) begin
            idle_gap($urandom_range(1, 25));
            // now and then a long stretch with no idling
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
         end
         send_numeral(pick_value(), 1'b0, "");
         burst_left--;
      end

      start <= 1'b0;
      @(posedge clock);
      while (expected_letters.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: roman_numeral_encoder_top.f
+incdir+design
design/rne_pkg.sv
design/rne_split.sv
design/rne_emit.sv
design/roman_numeral_encoder_top.sv
design/rne_checker.sv
tb/tb_top.sv
